@@ hdl/mountain_car_step_assert.svh @@
// ---------------------------------------------------------------------------
// mountain car step assertion macros
// shared concurrent assertion forms, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef MOUNTAIN_CAR_STEP_ASSERT_SVH
`define MOUNTAIN_CAR_STEP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, idle while rst_n is low
`define MCS_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// invariant on every clock
`define MCS_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`else

`define MCS_ASSERT_IMPLY(name, ante, cons, msg)
`define MCS_ASSERT_NEXT(name, ante, cons, msg)
`define MCS_ASSERT_ALWAYS(name, cond, msg)

`endif

`endif

@@ hdl/mcs_pkg.sv @@
// ---------------------------------------------------------------------------
// mcs_pkg
// types, constants and the gravity table shared by the mountain car step
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcs_pkg;

    // number format
    localparam int FRAC_BITS       = 24;
    localparam int COS_TABLE_DEPTH = 1024;
    localparam int DATA_W          = 32;
    localparam int REQ_W           = 2;
    localparam int ACT_W           = 2;
    localparam int BOUND_W         = 3;
    localparam int CFG_IDX_W       = 2;

    // stream payload widths, whole bytes
    localparam int IN_TDATA_W  = ((DATA_W + ACT_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 2 * DATA_W + BOUND_W + 2;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
    localparam int ACT_LSB     = DATA_W;

    // command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // cosine index path: |x| * 3/(2*pi) in Q32, turn fraction sits above FRAC_BITS
    localparam int LOG_D      = $clog2(COS_TABLE_DEPTH);
    localparam int HALF_DEPTH = COS_TABLE_DEPTH / 2;
    localparam int LOG_STEPS  = LOG_D + 2;
    localparam int K3_W      = 31;
    localparam logic [K3_W-1:0] K3 = 31'd2050695828;
    localparam int PROD_W    = DATA_W + K3_W;
    localparam int IDX_HI    = FRAC_BITS + 31;
    localparam int IDX_LO    = FRAC_BITS + 31 - LOG_STEPS;
    localparam int IDX_W     = LOG_STEPS + 1;

    // step constants
    localparam int COS_FRAC = 23;
    localparam int GSHIFT   = COS_FRAC + 40 - FRAC_BITS;
    localparam int G_W      = FRAC_BITS - 8;
    localparam int DELTA_W  = FRAC_BITS - 6;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint ACC_Q40     = 64'sd1099511628;
    localparam longint GRAV_Q40    = 64'sd2748779069;
    localparam longint ACC_VAL =
        (ACC_Q40 + (64'sd1 <<< (39 - FRAC_BITS))) >>> (40 - FRAC_BITS);
    localparam logic signed [DELTA_W-1:0] ACC_S = DELTA_W'(ACC_VAL);

    // register reset values
    localparam logic signed [DATA_W-1:0] POS_MIN_RST = -32'sd20132659;
    localparam logic signed [DATA_W-1:0] POS_MAX_RST = 32'sd10066330;
    localparam logic signed [DATA_W-1:0] VEL_MIN_RST = -32'sd1174405;
    localparam logic signed [DATA_W-1:0] VEL_MAX_RST = 32'sd1174405;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_POS = 2'd0,
        REQ_LOAD_VEL = 2'd1,
        REQ_STEP     = 2'd2,
        REQ_NONE     = 2'd3
    } mcs_req_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_ZERO    = 2'b00,
        ACT_PLUS    = 2'b01,
        ACT_INVALID = 2'b10,
        ACT_MINUS   = 2'b11
    } mcs_act_t;

    typedef enum logic [BOUND_W-1:0] {
        BOUND_NONE    = 3'd0,
        BOUND_MIN_POS = 3'd1,
        BOUND_MAX_POS = 3'd2,
        BOUND_MIN_VEL = 3'd3,
        BOUND_MAX_VEL = 3'd4
    } mcs_bound_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_MIN = 2'd0,
        CFG_POS_MAX = 2'd1,
        CFG_VEL_MIN = 2'd2,
        CFG_VEL_MAX = 2'd3
    } mcs_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROM,
        ST_VEL,
        ST_POS
    } mcs_state_t;

    typedef struct packed {
        mcs_req_t                  kind;
        logic signed [DATA_W-1:0]  load_value;
        logic                      accel_up;
        logic                      accel_dn;
        logic                      act_invalid;
    } mcs_cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_min;
        logic signed [DATA_W-1:0] pos_max;
        logic signed [DATA_W-1:0] vel_min;
        logic signed [DATA_W-1:0] vel_max;
    } mcs_limits_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] position;
        logic signed [DATA_W-1:0] velocity;
        mcs_bound_t               bound;
        logic                     act_invalid;
    } mcs_result_t;

    typedef logic [G_W-1:0] mcs_grav_rom_t [COS_TABLE_DEPTH];

    // truncating quotient of two non-negative values by shift and subtract
    function automatic longint series_div(longint num, longint den);
        longint quo;
        longint part;
        quo  = 0;
        part = 0;
        for (int b = 62; b >= 0; b--)
        begin
            part = (part <<< 1) | ((num >>> b) & 64'sd1);
            quo  = quo <<< 1;
            if (part >= den)
            begin
                part = part - den;
                quo  = quo | 64'sd1;
            end
        end
        return quo;
    endfunction

    // quarter-wave cosine by a ten-term series, then scaled by the gravity factor
    function automatic mcs_grav_rom_t build_grav_rom();
        mcs_grav_rom_t rom;
        longint theta;
        longint t2;
        longint term;
        longint sum;
        longint val;
        longint g;
        for (int k = 0; k < COS_TABLE_DEPTH; k++)
        begin
            theta = (longint'(k) * HALF_PI_Q30 + longint'(HALF_DEPTH)) >>> LOG_D;
            t2    = (theta * theta) >>> 30;
            term  = ONE_Q30;
            sum   = ONE_Q30;
            for (int n = 1; n <= 10; n++)
            begin
                term = (term * t2) >>> 30;
                term = series_div(term, longint'((2 * n - 1) * (2 * n)));
                if ((n & 1) != 0)
                begin
                    sum = sum - term;
                end
                else
                begin
                    sum = sum + term;
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            val = (sum + 64) >>> 7;
            if (val > (64'sd1 <<< COS_FRAC))
            begin
                val = 64'sd1 <<< COS_FRAC;
            end
            g      = (val * GRAV_Q40 + (64'sd1 <<< (GSHIFT - 1))) >>> GSHIFT;
            rom[k] = G_W'(g);
        end
        return rom;
    endfunction

    localparam mcs_grav_rom_t GRAV_ROM = build_grav_rom();

endpackage

`default_nettype wire

@@ hdl/mcs_front.sv @@
// ---------------------------------------------------------------------------
// mcs_front
// accepts input items and decodes them into queue commands
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcs_front
(
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [mcs_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  wire logic [mcs_pkg::REQ_W-1:0]         s_tuser,
    input  wire logic                              queue_full,
    output logic                                   push,
    output mcs_pkg::mcs_cmd_t                      cmd
);

    mcs_pkg::mcs_req_t kind;
    mcs_pkg::mcs_act_t act;
    logic              is_step;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb
    begin
        kind    = mcs_pkg::mcs_req_t'(s_tuser);
        act     = mcs_pkg::mcs_act_t'(s_tdata[mcs_pkg::ACT_LSB +: mcs_pkg::ACT_W]);
        is_step = (kind == mcs_pkg::REQ_STEP);

        cmd.kind        = kind;
        cmd.load_value  = signed'(s_tdata[mcs_pkg::DATA_W-1:0]);
        cmd.accel_up    = 1'b0;
        cmd.accel_dn    = 1'b0;
        cmd.act_invalid = 1'b0;

        // throttle only matters on a step; the invalid code drives as zero
        unique case (act)
            mcs_pkg::ACT_ZERO:    cmd.accel_up    = 1'b0;
            mcs_pkg::ACT_PLUS:    cmd.accel_up    = is_step;
            mcs_pkg::ACT_MINUS:   cmd.accel_dn    = is_step;
            mcs_pkg::ACT_INVALID: cmd.act_invalid = is_step;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/mcs_queue.sv @@
// ---------------------------------------------------------------------------
// mcs_queue
// short command fifo between the decode front and the execution back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mountain_car_step_assert.svh"

module mcs_queue
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire mcs_pkg::mcs_cmd_t  push_cmd,
    input  wire logic               pop,
    output logic                    head_valid,
    output mcs_pkg::mcs_cmd_t       head_cmd,
    output logic                    full
);

    mcs_pkg::mcs_cmd_t               q_mem [mcs_pkg::QUEUE_DEPTH];
    logic [mcs_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [mcs_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [mcs_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [mcs_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [mcs_pkg::QPTR_W:0]        count_reg;
    logic [mcs_pkg::QPTR_W:0]        count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == (mcs_pkg::QPTR_W + 1)'(mcs_pkg::QUEUE_DEPTH));
    assign head_cmd   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    `MCS_ASSERT_ALWAYS(a_count_range, count_reg <= (mcs_pkg::QPTR_W + 1)'(mcs_pkg::QUEUE_DEPTH), "queue count beyond depth")
    `MCS_ASSERT_IMPLY(a_pop_nonempty, pop, head_valid, "pop from empty queue")

endmodule

`default_nettype wire

@@ hdl/mcs_back.sv @@
// ---------------------------------------------------------------------------
// mcs_back
// executes load and step commands on the car state and holds the result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mountain_car_step_assert.svh"

module mcs_back
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mcs_pkg::mcs_limits_t  limits,
    input  wire logic                  head_valid,
    input  wire mcs_pkg::mcs_cmd_t     head_cmd,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output mcs_pkg::mcs_result_t       result
);

    localparam int DW = mcs_pkg::DATA_W;

    mcs_pkg::mcs_state_t        state_reg;
    mcs_pkg::mcs_state_t        state_next;
    logic signed [DW-1:0]       pos_reg;
    logic signed [DW-1:0]       pos_next;
    logic signed [DW-1:0]       vel_reg;
    logic signed [DW-1:0]       vel_next;
    mcs_pkg::mcs_bound_t        bound_reg;
    mcs_pkg::mcs_bound_t        bound_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    mcs_pkg::mcs_result_t       out_reg;
    mcs_pkg::mcs_result_t       out_next;
    logic                       out_load;
    logic                       out_free;
    logic                       step_start;

    // step payload
    logic [mcs_pkg::IDX_W-1:0]  prod_idx_reg;
    logic                       step_up_reg;
    logic                       step_dn_reg;
    logic                       step_inv_reg;
    logic [mcs_pkg::G_W-1:0]    g_mag_reg;
    logic                       g_neg_reg;
    logic                       g_zero_reg;

    // limits
    logic signed [DW-1:0]       pmin;
    logic signed [DW-1:0]       pmax;
    logic signed [DW-1:0]       vmin;
    logic signed [DW-1:0]       vmax;
    logic signed [DW:0]         pmin_w;
    logic signed [DW:0]         pmax_w;
    logic signed [DW:0]         vmin_w;
    logic signed [DW:0]         vmax_w;

    // cosine index path
    logic [DW-1:0]                  abs_x;
    logic [mcs_pkg::PROD_W-1:0]     prod;
    logic [mcs_pkg::LOG_STEPS-1:0]  idx;
    logic [1:0]                     quad;
    logic [mcs_pkg::LOG_D-1:0]      rem;
    logic [mcs_pkg::LOG_D-1:0]      rom_addr;

    // load bound path
    logic signed [DW-1:0]       x_in;
    logic signed [DW-1:0]       v_in;
    logic signed [DW-1:0]       v_mid;
    logic signed [DW-1:0]       x_ld;
    logic signed [DW-1:0]       v_ld;
    mcs_pkg::mcs_bound_t        bound_ld;
    logic                       p_le;
    logic                       p_ge;
    logic                       v_lt;
    logic                       v_gt;

    // step velocity and position path
    logic [mcs_pkg::G_W-1:0]            g_eff;
    logic signed [mcs_pkg::DELTA_W-1:0] acc_term;
    logic signed [mcs_pkg::DELTA_W-1:0] g_term;
    logic signed [mcs_pkg::DELTA_W-1:0] delta;
    logic signed [DW:0]                 v_sum;
    logic signed [DW-1:0]               v_step;
    logic signed [DW:0]                 x_sum;
    logic signed [DW-1:0]               x_step;
    logic                               x_lt;

    assign pmin   = limits.pos_min;
    assign pmax   = limits.pos_max;
    assign vmin   = limits.vel_min;
    assign vmax   = limits.vel_max;
    assign pmin_w = {pmin[DW-1], pmin};
    assign pmax_w = {pmax[DW-1], pmax};
    assign vmin_w = {vmin[DW-1], vmin};
    assign vmax_w = {vmax[DW-1], vmax};

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

    // cos is even: work on |x|, scaled by 3/(2*pi) in one product
    always_comb
    begin
        abs_x    = pos_reg[DW-1] ? (~pos_reg + 1'b1) : pos_reg;
        prod     = mcs_pkg::PROD_W'(abs_x) * mcs_pkg::PROD_W'(mcs_pkg::K3);
        idx      = prod_idx_reg[mcs_pkg::IDX_W-1:1]
                   + mcs_pkg::LOG_STEPS'(prod_idx_reg[0]);
        quad     = idx[mcs_pkg::LOG_STEPS-1:mcs_pkg::LOG_D];
        rem      = idx[mcs_pkg::LOG_D-1:0];
        rom_addr = quad[0] ? (~rem + 1'b1) : rem;
    end

    // load bound rule
    always_comb
    begin
        x_in  = (head_cmd.kind == mcs_pkg::REQ_LOAD_POS) ? head_cmd.load_value : pos_reg;
        v_in  = (head_cmd.kind == mcs_pkg::REQ_LOAD_VEL) ? head_cmd.load_value : vel_reg;
        p_le  = (x_in <= pmin);
        p_ge  = (x_in >= pmax);
        v_mid = (p_le || p_ge) ? '0 : v_in;
        v_lt  = (v_mid < vmin);
        v_gt  = (v_mid > vmax);
        priority if (p_le)
        begin
            x_ld     = pmin;
            bound_ld = mcs_pkg::BOUND_MIN_POS;
        end
        else if (p_ge)
        begin
            x_ld     = pmax;
            bound_ld = mcs_pkg::BOUND_MAX_POS;
        end
        else
        begin
            x_ld     = x_in;
            bound_ld = mcs_pkg::BOUND_NONE;
        end
        priority if (v_lt)
        begin
            v_ld     = vmin;
            bound_ld = mcs_pkg::BOUND_MIN_VEL;
        end
        else if (v_gt)
        begin
            v_ld     = vmax;
            bound_ld = mcs_pkg::BOUND_MAX_VEL;
        end
        else
        begin
            v_ld = v_mid;
        end
    end

    // step arithmetic
    always_comb
    begin
        g_eff    = g_zero_reg ? '0 : g_mag_reg;
        g_term   = signed'({{(mcs_pkg::DELTA_W - mcs_pkg::G_W){1'b0}}, g_eff});
        priority if (step_up_reg)
        begin
            acc_term = mcs_pkg::ACC_S;
        end
        else if (step_dn_reg)
        begin
            acc_term = -mcs_pkg::ACC_S;
        end
        else
        begin
            acc_term = '0;
        end
        delta  = g_neg_reg ? (acc_term + g_term) : (acc_term - g_term);
        v_sum  = {vel_reg[DW-1], vel_reg}
                 + {{(DW + 1 - mcs_pkg::DELTA_W){delta[mcs_pkg::DELTA_W-1]}}, delta};
        // min first, then max: crossed limits end at the max
        if (v_sum < vmin_w)
        begin
            v_step = (vmin > vmax) ? vmax : vmin;
        end
        else if (v_sum > vmax_w)
        begin
            v_step = vmax;
        end
        else
        begin
            v_step = v_sum[DW-1:0];
        end

        x_sum = {pos_reg[DW-1], pos_reg} + {vel_reg[DW-1], vel_reg};
        x_lt  = (x_sum < pmin_w);
        if (x_lt)
        begin
            x_step = (pmin > pmax) ? pmax : pmin;
        end
        else if (x_sum > pmax_w)
        begin
            x_step = pmax;
        end
        else
        begin
            x_step = x_sum[DW-1:0];
        end
    end

    // sequencer: loads finish in the idle state, steps walk rom, vel, pos
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        bound_next     = bound_reg;
        out_next       = out_reg;
        out_load       = 1'b0;
        pop            = 1'b0;
        step_start     = 1'b0;

        unique case (state_reg)
            mcs_pkg::ST_IDLE:
            begin
                if (head_valid && (out_free || head_cmd.kind == mcs_pkg::REQ_STEP))
                begin
                    pop = 1'b1;
                    if (head_cmd.kind == mcs_pkg::REQ_STEP)
                    begin
                        step_start = 1'b1;
                        state_next = mcs_pkg::ST_ROM;
                    end
                    else
                    begin
                        if (head_cmd.kind != mcs_pkg::REQ_NONE)
                        begin
                            pos_next   = x_ld;
                            vel_next   = v_ld;
                            bound_next = bound_ld;
                        end
                        out_load             = 1'b1;
                        out_next.position    = pos_next;
                        out_next.velocity    = vel_next;
                        out_next.bound       = bound_next;
                        out_next.act_invalid = 1'b0;
                    end
                end
            end
            mcs_pkg::ST_ROM:
            begin
                state_next = mcs_pkg::ST_VEL;
            end
            mcs_pkg::ST_VEL:
            begin
                vel_next   = v_step;
                state_next = mcs_pkg::ST_POS;
            end
            mcs_pkg::ST_POS:
            begin
                if (out_free)
                begin
                    pos_next             = x_step;
                    vel_next             = x_lt ? '0 : vel_reg;
                    out_load             = 1'b1;
                    out_next.position    = pos_next;
                    out_next.velocity    = vel_next;
                    out_next.bound       = bound_reg;
                    out_next.act_invalid = step_inv_reg;
                    state_next           = mcs_pkg::ST_IDLE;
                end
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcs_pkg::ST_IDLE;
            pos_reg       <= '0;
            vel_reg       <= '0;
            bound_reg     <= mcs_pkg::BOUND_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
            bound_reg     <= bound_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_start)
        begin
            prod_idx_reg <= prod[mcs_pkg::IDX_HI:mcs_pkg::IDX_LO];
            step_up_reg  <= head_cmd.accel_up;
            step_dn_reg  <= head_cmd.accel_dn;
            step_inv_reg <= head_cmd.act_invalid;
        end
        if (state_reg == mcs_pkg::ST_ROM)
        begin
            g_mag_reg  <= mcs_pkg::GRAV_ROM[rom_addr];
            g_neg_reg  <= quad[1] ^ quad[0];
            g_zero_reg <= quad[0] && (rem == '0);
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    `MCS_ASSERT_IMPLY(a_no_pop_busy, state_reg != mcs_pkg::ST_IDLE, !pop, "queue popped during a step")
    `MCS_ASSERT_NEXT(a_step_enters_rom, step_start, state_reg == mcs_pkg::ST_ROM, "step did not reach rom stage")
    `MCS_ASSERT_IMPLY(a_result_source, out_load, (state_reg == mcs_pkg::ST_IDLE) || (state_reg == mcs_pkg::ST_POS), "result written mid step")

endmodule

`default_nettype wire

@@ hdl/mountain_car_step.sv @@
// ---------------------------------------------------------------------------
// mountain_car_step
// mountain car dynamics in signed Q8.24 with load and step commands
// ---------------------------------------------------------------------------
// Each input item is a load position, load velocity or physics step command
// and yields exactly one result item with the car state afterwards. Loads
// (and the unused request code) finish in idle and stream one item per clock
// while the result register is free. A step passes through the product
// |x| * 3/(2*pi), the registered gravity table read, the velocity update
// and the position update; the next step needs the position that the last
// one wrote. A four-item queue after the decode front keeps s_tready high
// during a step until full, and the result register lets a new item be taken
// while the previous result waits on m_tready. Limits must be written through
// the cfg port only while no item is in flight; the block doesn't enforce it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mountain_car_step
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [31:0] load_value, [33:32] action, [39:34] zero
    input  wire logic [mcs_pkg::IN_TDATA_W-1:0]    s_tdata,
    // [1:0] req_type
    input  wire logic [mcs_pkg::REQ_W-1:0]         s_tuser,

    // result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] position, [63:32] velocity, [66:64] bound_status,
    // [67] unbounded_flag, [68] action_invalid, [71:69] zero
    output logic [mcs_pkg::OUT_TDATA_W-1:0]        m_tdata,

    // limit registers: 0 pos_min, 1 pos_max, 2 vel_min, 3 vel_max
    input  wire logic                              cfg_we,
    input  wire logic [mcs_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [mcs_pkg::DATA_W-1:0]        cfg_wdata
);

    mcs_pkg::mcs_limits_t  limits_reg;
    mcs_pkg::mcs_cmd_t     push_cmd;
    mcs_pkg::mcs_cmd_t     head_cmd;
    mcs_pkg::mcs_result_t  result;
    logic                  push;
    logic                  pop;
    logic                  head_valid;
    logic                  queue_full;

    // limit registers, reset to the classic -1.2 .. 0.6 and +-0.07
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.pos_min <= mcs_pkg::POS_MIN_RST;
            limits_reg.pos_max <= mcs_pkg::POS_MAX_RST;
            limits_reg.vel_min <= mcs_pkg::VEL_MIN_RST;
            limits_reg.vel_max <= mcs_pkg::VEL_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (mcs_pkg::mcs_cfg_t'(cfg_addr))
                mcs_pkg::CFG_POS_MIN: limits_reg.pos_min <= signed'(cfg_wdata);
                mcs_pkg::CFG_POS_MAX: limits_reg.pos_max <= signed'(cfg_wdata);
                mcs_pkg::CFG_VEL_MIN: limits_reg.vel_min <= signed'(cfg_wdata);
                mcs_pkg::CFG_VEL_MAX: limits_reg.vel_max <= signed'(cfg_wdata);
            endcase
        end
    end

    // decode front: request kind and throttle code into a command
    mcs_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    // command queue decouples acceptance from execution
    mcs_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .full       (queue_full)
    );

    // execution back end with car state and result register
    mcs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .limits     (limits_reg),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result     (result)
    );

    // unbounded flag derived from the recorded load status
    assign m_tdata = {{mcs_pkg::OUT_PAD_W{1'b0}},
                      result.act_invalid,
                      (result.bound == mcs_pkg::BOUND_NONE),
                      result.bound,
                      result.velocity,
                      result.position};

endmodule

`default_nettype wire

@@ tb/mountain_car_step_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mountain_car_step_checker
// Watches the item and result streams and the limit port. Keeps its own copy
// of the car state and limits, predicts each result and compares it field by
// field.
// ---------------------------------------------------------------------------
module mountain_car_step_checker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [mcs_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [mcs_pkg::REQ_W-1:0]       s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [mcs_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [mcs_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [mcs_pkg::DATA_W-1:0]      cfg_wdata,
    output int                                   fail_count,
    output int                                   result_count,
    output int                                   pending
);
    import mcs_pkg::*;

    localparam int              TURN_STEPS       = 4 * COS_TABLE_DEPTH;
    localparam int              COS_Q            = 23;
    localparam int              PULL_SHIFT       = COS_Q + 40 - FRAC_BITS;
    localparam longint unsigned RIGHT_ANGLE_Q30  = 64'd1686629713;
    localparam longint unsigned TURN_PER_RAD_Q32 = 64'd683565276;
    localparam longint unsigned THRUST_Q40       = 64'd1099511628;
    localparam longint unsigned GRAVITY_Q40      = 64'd2748779069;
    localparam longint          THRUST           =
        longint'((THRUST_Q40 + (64'd1 << (39 - FRAC_BITS))) >> (40 - FRAC_BITS));

    typedef struct packed {
        logic [DATA_W-1:0] position;
        logic [DATA_W-1:0] velocity;
        mcs_bound_t        bound;
        logic              unbounded;
        logic              act_invalid;
    } car_result_t;

    longint unsigned cos_q23 [COS_TABLE_DEPTH];
    longint          car_x;
    longint          car_v;
    mcs_bound_t      load_bound;
    longint          pos_lo;
    longint          pos_hi;
    longint          vel_lo;
    longint          vel_hi;
    car_result_t     awaited_q [$];

    // quarter-wave cosine, ten-term series in Q30, rounded to Q23
    initial
    begin : fill_cosine
        longint unsigned theta;
        longint unsigned t2;
        longint unsigned term;
        longint          sum;
        for (int k = 0; k < COS_TABLE_DEPTH; k++)
        begin
            theta = (64'(k) * RIGHT_ANGLE_Q30 + COS_TABLE_DEPTH / 2) / COS_TABLE_DEPTH;
            t2    = (theta * theta) >> 30;
            term  = 64'd1 << 30;
            sum   = 64'sd1 <<< 30;
            for (int n = 1; n <= 10; n++)
            begin
                term = (term * t2) >> 30;
                term = term / ((2 * n - 1) * (2 * n));
                if (n % 2 == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            cos_q23[k] = (sum + 64) >> 7;
            if (cos_q23[k] > (64'd1 << COS_Q))
            begin
                cos_q23[k] = 64'd1 << COS_Q;
            end
        end
    end

    // signed gravity term 0.0025*cos(3x) at the block's fraction width
    function automatic longint gravity_pull(longint x);
        longint          angle;
        longint unsigned mag;
        longint unsigned turn;
        longint unsigned slot;
        longint unsigned quarter;
        longint unsigned offset;
        longint unsigned cmag;
        longint unsigned pull;
        angle   = 3 * x;
        mag     = (angle < 0) ? -angle : angle;
        turn    = ((mag * TURN_PER_RAD_Q32) >> FRAC_BITS) & 64'hFFFF_FFFF;
        slot    = ((turn * TURN_STEPS + 64'h8000_0000) >> 32) % TURN_STEPS;
        quarter = slot / COS_TABLE_DEPTH;
        offset  = slot % COS_TABLE_DEPTH;
        if (quarter == 0 || quarter == 2)
        begin
            cmag = cos_q23[offset];
        end
        else if (offset == 0)
        begin
            cmag = 0;
        end
        else
        begin
            cmag = cos_q23[COS_TABLE_DEPTH - offset];
        end
        pull = (cmag * GRAVITY_Q40 + (64'd1 << (PULL_SHIFT - 1))) >> PULL_SHIFT;
        return (quarter == 1 || quarter == 2) ? -longint'(pull) : longint'(pull);
    endfunction

    function automatic car_result_t advance_car(mcs_req_t req, longint load, mcs_act_t act);
        car_result_t r;
        longint      nv;
        longint      nx;
        logic        bad;
        bad = 1'b0;
        case (req)
            REQ_LOAD_POS, REQ_LOAD_VEL:
            begin
                if (req == REQ_LOAD_POS)
                begin
                    car_x = load;
                end
                else
                begin
                    car_v = load;
                end
                load_bound = BOUND_NONE;
                if (car_x <= pos_lo)
                begin
                    car_x      = pos_lo;
                    car_v      = 0;
                    load_bound = BOUND_MIN_POS;
                end
                else if (car_x >= pos_hi)
                begin
                    car_x      = pos_hi;
                    car_v      = 0;
                    load_bound = BOUND_MAX_POS;
                end
                if (car_v < vel_lo)
                begin
                    car_v      = vel_lo;
                    load_bound = BOUND_MIN_VEL;
                end
                else if (car_v > vel_hi)
                begin
                    car_v      = vel_hi;
                    load_bound = BOUND_MAX_VEL;
                end
            end
            REQ_STEP:
            begin
                nv = car_v - gravity_pull(car_x);
                case (act)
                    ACT_PLUS:    nv = nv + THRUST;
                    ACT_MINUS:   nv = nv - THRUST;
                    ACT_INVALID: bad = 1'b1;
                    default:     ;
                endcase
                if (nv < vel_lo)
                begin
                    nv = vel_lo;
                end
                if (nv > vel_hi)
                begin
                    nv = vel_hi;
                end
                car_v = nv;
                nx    = car_x + nv;
                // only the lower wall stops the car
                if (nx < pos_lo)
                begin
                    nx    = pos_lo;
                    car_v = 0;
                end
                if (nx > pos_hi)
                begin
                    nx = pos_hi;
                end
                car_x = nx;
            end
            default: ;
        endcase
        r.position    = car_x[DATA_W-1:0];
        r.velocity    = car_v[DATA_W-1:0];
        r.bound       = load_bound;
        r.unbounded   = (load_bound == BOUND_NONE);
        r.act_invalid = bad;
        return r;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        car_result_t want;
        longint      got_pos;
        longint      got_vel;
        if (!rst_n)
        begin
            car_x        = 0;
            car_v        = 0;
            load_bound   = BOUND_NONE;
            pos_lo       = longint'(POS_MIN_RST);
            pos_hi       = longint'(POS_MAX_RST);
            vel_lo       = longint'(VEL_MIN_RST);
            vel_hi       = longint'(VEL_MAX_RST);
            fail_count   = 0;
            result_count = 0;
            awaited_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (mcs_cfg_t'(cfg_addr))
                    CFG_POS_MIN: pos_lo = longint'($signed(cfg_wdata));
                    CFG_POS_MAX: pos_hi = longint'($signed(cfg_wdata));
                    CFG_VEL_MIN: vel_lo = longint'($signed(cfg_wdata));
                    CFG_VEL_MAX: vel_hi = longint'($signed(cfg_wdata));
                    default:     ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                result_count++;
                got_pos = longint'($signed(m_tdata[DATA_W-1:0]));
                got_vel = longint'($signed(m_tdata[2*DATA_W-1:DATA_W]));
                if (awaited_q.size() == 0)
                begin
                    $error("result item with no prediction waiting: position %0d", got_pos);
                    fail_count++;
                end
                else
                begin
                    want = awaited_q.pop_front();
                    compare_field("position", longint'($signed(want.position)), got_pos);
                    compare_field("velocity", longint'($signed(want.velocity)), got_vel);
                    compare_field("bound_status", longint'(want.bound),
                                  longint'(m_tdata[2*DATA_W +: BOUND_W]));
                    compare_field("unbounded_flag", longint'(want.unbounded),
                                  longint'(m_tdata[2*DATA_W+BOUND_W]));
                    compare_field("action_invalid", longint'(want.act_invalid),
                                  longint'(m_tdata[2*DATA_W+BOUND_W+1]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                awaited_q.push_back(advance_car(mcs_req_t'(s_tuser),
                                                longint'($signed(s_tdata[DATA_W-1:0])),
                                                mcs_act_t'(s_tdata[ACT_LSB +: ACT_W])));
            end
        end
        pending = awaited_q.size();
    end

endmodule

@@ tb/tb_mountain_car_step.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_mountain_car_step
// Self-checking bench for the mountain car step block. Drives load, step and
// unused requests with random stalls on both streams, moves the limit
// registers through default, full-range, crossed, random and zero settings
// between phases, and lets the checker predict and compare every result.
// ---------------------------------------------------------------------------
module tb_mountain_car_step;
    import mcs_pkg::*;

    // receiver hold-off long enough to fill the command queue and result register
    localparam int LONG_STALL   = 48;
    // longer than a step spends in the back end
    localparam int SETTLE       = 12;
    // well over the slowest run of ~750 items
    localparam int RUN_LIMIT_NS = 400_000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // [31:0] load_value, [33:32] action, [39:34] zero
    logic [IN_TDATA_W-1:0]  s_tdata;
    // [1:0] req_type
    logic [REQ_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // [31:0] position, [63:32] velocity, [66:64] bound_status,
    // [67] unbounded_flag, [68] action_invalid, [71:69] zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [DATA_W-1:0]      cfg_wdata;

    int fail_count;
    int result_count;
    int pending;

    // random gaps on both streams while set
    logic idling        = 1'b1;
    // raised by the item side, taken by the result side for one long hold-off
    logic stall_request = 1'b0;

    int sent_count    = 0;
    int loads_sent    = 0;
    int steps_sent    = 0;
    int invalid_sent  = 0;
    int other_sent    = 0;
    int settings_used = 1;

    // limits currently in the block, used to aim load values
    longint pos_lo = longint'(POS_MIN_RST);
    longint pos_hi = longint'(POS_MAX_RST);
    longint vel_lo = longint'(VEL_MIN_RST);
    longint vel_hi = longint'(VEL_MAX_RST);

    mountain_car_step dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    mountain_car_step_checker car_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .result_count (result_count),
        .pending      (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // offer one item and hold it until the block takes it
    task automatic send_item(input mcs_req_t req, input logic [DATA_W-1:0] value,
                             input mcs_act_t act);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(IN_TDATA_W - DATA_W - ACT_W){1'b0}}, act, value};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sent_count++;
        case (req)
            REQ_LOAD_POS, REQ_LOAD_VEL: loads_sent++;
            REQ_STEP:
            begin
                steps_sent++;
                if (act == ACT_INVALID)
                begin
                    invalid_sent++;
                end
            end
            default: other_sent++;
        endcase
    endtask

    // stop offering, let every outstanding result arrive, then let the back end settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (result_count != sent_count);
        repeat (SETTLE) @(posedge clk);
    endtask

    // all four limits in consecutive cycles, enable held high throughout
    task automatic write_limits(input longint pmin, input longint pmax,
                                input longint vmin, input longint vmax);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_POS_MIN;
        cfg_wdata <= DATA_W'(pmin);
        @(posedge clk);
        cfg_addr  <= CFG_POS_MAX;
        cfg_wdata <= DATA_W'(pmax);
        @(posedge clk);
        cfg_addr  <= CFG_VEL_MIN;
        cfg_wdata <= DATA_W'(vmin);
        @(posedge clk);
        cfg_addr  <= CFG_VEL_MAX;
        cfg_wdata <= DATA_W'(vmax);
        @(posedge clk);
        cfg_we    <= 1'b0;
        pos_lo = longint'($signed(DATA_W'(pmin)));
        pos_hi = longint'($signed(DATA_W'(pmax)));
        vel_lo = longint'($signed(DATA_W'(vmin)));
        vel_hi = longint'($signed(DATA_W'(vmax)));
        settings_used++;
    endtask

    // mostly valid throttle, now and then the invalid code
    function automatic mcs_act_t pick_throttle();
        if ($urandom_range(0, 15) == 0)
        begin
            return ACT_INVALID;
        end
        case ($urandom_range(0, 2))
            0:       return ACT_MINUS;
            1:       return ACT_ZERO;
            default: return ACT_PLUS;
        endcase
    endfunction

    // value inside [lo, hi], sometimes right on or just past a limit
    function automatic logic [DATA_W-1:0] pick_in(input longint lo, input longint hi);
        longint unsigned span;
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 5))
                0:       return DATA_W'(lo);
                1:       return DATA_W'(hi);
                2:       return DATA_W'(lo - 1);
                3:       return DATA_W'(lo + 1);
                4:       return DATA_W'(hi - 1);
                default: return DATA_W'(hi + 1);
            endcase
        end
        if (lo > hi)
        begin
            return $urandom;
        end
        span = longint'(hi - lo) + 1;
        return DATA_W'(lo + longint'({$urandom, $urandom} % span));
    endfunction

    // mostly short episodes (start position, start velocity, run of steps),
    // the rest single items with every field random
    task automatic run_phase(input int n_items);
        int done;
        int run_len;
        done = 0;
        while (done < n_items)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                send_item(REQ_LOAD_POS, pick_in(pos_lo, pos_hi), mcs_act_t'($urandom_range(0, 3)));
                send_item(REQ_LOAD_VEL, pick_in(vel_lo, vel_hi), mcs_act_t'($urandom_range(0, 3)));
                run_len = $urandom_range(3, 24);
                for (int k = 0; k < run_len; k++)
                begin
                    send_item(REQ_STEP, $urandom, pick_throttle());
                end
                done += run_len + 2;
            end
            else
            begin
                send_item(mcs_req_t'($urandom_range(0, 3)), $urandom,
                          mcs_act_t'($urandom_range(0, 3)));
                done++;
            end
        end
    endtask

    // result side: random short stalls, one long hold-off on request
    initial
    begin : receiver
        m_tready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (stall_request)
            begin
                stall_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under reset limits
        // every throttle from rest, the invalid code included
        send_item(REQ_STEP, 32'h0000_0000, ACT_ZERO);
        send_item(REQ_STEP, 32'hFFFF_FFFF, ACT_PLUS);
        send_item(REQ_STEP, 32'h0000_0000, ACT_MINUS);
        send_item(REQ_STEP, 32'h5555_5555, ACT_INVALID);
        // load extremes: position clamps zero the velocity
        send_item(REQ_LOAD_POS, 32'h7FFF_FFFF, ACT_INVALID);
        send_item(REQ_LOAD_POS, 32'h8000_0000, ACT_PLUS);
        // car still on the lower wall, so a velocity load is cancelled
        send_item(REQ_LOAD_VEL, 32'h7FFF_FFFF, ACT_MINUS);
        send_item(REQ_LOAD_POS, 32'h0000_0000, ACT_ZERO);
        send_item(REQ_LOAD_VEL, 32'h7FFF_FFFF, ACT_ZERO);
        send_item(REQ_LOAD_VEL, 32'h8000_0000, ACT_ZERO);
        // exactly on the limits: velocity passes, position counts as clamped
        send_item(REQ_LOAD_VEL, DATA_W'(vel_hi), ACT_ZERO);
        send_item(REQ_LOAD_VEL, DATA_W'(vel_lo), ACT_ZERO);
        send_item(REQ_LOAD_POS, DATA_W'(pos_lo), ACT_ZERO);
        send_item(REQ_LOAD_POS, DATA_W'(pos_hi), ACT_ZERO);
        // drive into the lower wall
        send_item(REQ_LOAD_POS, DATA_W'(pos_lo + 1), ACT_ZERO);
        send_item(REQ_LOAD_VEL, DATA_W'(vel_lo), ACT_ZERO);
        send_item(REQ_STEP, 32'h0000_0000, ACT_MINUS);
        send_item(REQ_STEP, 32'h0000_0000, ACT_MINUS);
        // run past the upper wall, velocity survives there
        send_item(REQ_LOAD_POS, DATA_W'(pos_hi - 1), ACT_ZERO);
        send_item(REQ_LOAD_VEL, DATA_W'(vel_hi), ACT_ZERO);
        send_item(REQ_STEP, 32'h0000_0000, ACT_PLUS);
        // unused request reports the state, never flags the action
        send_item(REQ_NONE, 32'hFFFF_FFFF, ACT_INVALID);
        // 3x on a quarter-turn and a half-turn boundary of the cosine
        send_item(REQ_LOAD_POS, 32'd8784530, ACT_ZERO);
        send_item(REQ_STEP, 32'h0000_0000, ACT_ZERO);
        send_item(REQ_LOAD_POS, DATA_W'(-64'sd17569060), ACT_ZERO);
        send_item(REQ_STEP, 32'h0000_0000, ACT_ZERO);
        wait_drained();

        // back-pressure: result side holds off while steps keep coming
        idling        = 1'b0;
        stall_request = 1'b1;
        for (int k = 0; k < 20; k++)
        begin
            send_item(REQ_STEP, $urandom, pick_throttle());
        end
        wait_drained();
        idling = 1'b1;

        // default limits
        run_phase(150);
        wait_drained();

        // full-range limits: wide sums clamp at the register extremes
        write_limits(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647);
        run_phase(120);
        wait_drained();

        // crossed limits, min above max on both axes
        write_limits(64'sd8388608, -64'sd8388608, 64'sd335544, -64'sd335544);
        run_phase(80);
        wait_drained();

        // random window around zero
        write_limits(-longint'($urandom_range(1 << 20, 1 << 26)),
                     longint'($urandom_range(1 << 20, 1 << 26)),
                     -longint'($urandom_range(1 << 12, 1 << 22)),
                     longint'($urandom_range(1 << 12, 1 << 22)));
        run_phase(150);
        wait_drained();

        // degenerate: every limit at zero
        write_limits(0, 0, 0, 0);
        run_phase(40);
        wait_drained();

        // last part back at the defaults, both streams flat out
        idling = 1'b0;
        write_limits(longint'(POS_MIN_RST), longint'(POS_MAX_RST),
                     longint'(VEL_MIN_RST), longint'(VEL_MAX_RST));
        run_phase(150);
        wait_drained();

        $display("run: %0d items, %0d loads, %0d steps (%0d invalid throttle), %0d unused",
                 sent_count, loads_sent, steps_sent, invalid_sent, other_sent);
        $display("%0d results compared over %0d limit settings incl. crossed and full range",
                 result_count, settings_used);
        if (fail_count == 0 && pending == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/mcs_pkg.sv
hdl/mcs_front.sv
hdl/mcs_queue.sv
hdl/mcs_back.sv
hdl/mountain_car_step.sv
tb/mountain_car_step_checker.sv
tb/tb_mountain_car_step.sv
